// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge, disabled during reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/fmpf_pkg.sv =====
// Package with operation, status and command types of the packet filter table.
`timescale 1ns / 1ps
package fmpf_pkg;
    localparam logic [1:0] OP_CHECK  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Rule word: src(32) smask(32) dst(32) dmask(32) proto(8) sport(16) dport(16) act(1)
    localparam int RULE_W = 169;
    localparam int ID_W   = 32;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture request fields
        logic scan_rst;   // restart slot address
        logic scan_adv;   // advance slot address
        logic eval;       // slot data valid this cycle
        logic clr_valid;  // invalidate all slots
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic last;       // evaluated slot was the last
        logic hit;        // evaluated slot matched the request
    } t_stat;
endpackage

// ===== design/first_match_packet_filter_table.sv =====
// Top level of the first-match packet filter table.
// A request is taken when start is high and busy is low; its single result
// appears on o_verdict, o_status and o_assigned_id for one cycle with o_done
// and cannot be stalled. Clear empties the table without a scan; check, add and
// delete walk the rule memory one slot per cycle through its single read port
// and stop at the first hit or after the last slot. Reset empties the table at
// once and sets the next rule id to 1.
`timescale 1ns / 1ps
module first_match_packet_filter_table #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    output logic        o_done,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [31:0] i_src_addr_mask,
    input  logic [31:0] i_dst_addr_mask,
    input  logic [7:0]  i_protocol,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic        i_ports_present,
    input  logic        i_rule_action,
    input  logic [31:0] i_rule_id,
    output logic        o_verdict,
    output logic [1:0]  o_status,
    output logic [31:0] o_assigned_id
);
    fmpf_pkg::t_cmd  w_cmd;
    fmpf_pkg::t_stat w_stat;
    logic w_busy, w_finish;

    fmpf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_operation(i_operation),
        .i_stat(w_stat), .o_cmd(w_cmd), .o_busy(w_busy), .o_finish(w_finish)
    );

    fmpf_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_operation(i_operation), .i_src_addr(i_src_addr), .i_dst_addr(i_dst_addr),
        .i_src_addr_mask(i_src_addr_mask), .i_dst_addr_mask(i_dst_addr_mask),
        .i_protocol(i_protocol), .i_src_port(i_src_port), .i_dst_port(i_dst_port),
        .i_ports_present(i_ports_present), .i_rule_action(i_rule_action),
        .i_rule_id(i_rule_id), .o_stat(w_stat), .o_verdict(o_verdict),
        .o_status(o_status), .o_assigned_id(o_assigned_id)
    );

    assign busy = w_busy;
    assign o_done = w_finish;
endmodule

// ===== design/fmpf_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module fmpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read the array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== design/fmpf_ctrl.sv =====
// Controller state machine of the packet filter table.
`timescale 1ns / 1ps
module fmpf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_operation,
    input  fmpf_pkg::t_stat i_stat,
    output fmpf_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_finish
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRIME = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [2:0] r_state, n_state;

    // Sequence the scan
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    o_cmd.scan_rst = 1'b1;
                    if (i_operation == fmpf_pkg::OP_CLEAR) begin
                        o_cmd.clr_valid = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_PRIME;
                    end
                end
            end
            S_PRIME: begin
                o_cmd.scan_adv = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.eval = 1'b1;
                o_cmd.scan_adv = 1'b1;
                if (i_stat.hit || i_stat.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// ===== design/fmpf_dpath.sv =====
// Datapath of the packet filter table: rule memories, valid bits, match logic.
`timescale 1ns / 1ps
module fmpf_dpath #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fmpf_pkg::t_cmd  i_cmd,
    input  logic [1:0]      i_operation,
    input  logic [31:0]     i_src_addr,
    input  logic [31:0]     i_dst_addr,
    input  logic [31:0]     i_src_addr_mask,
    input  logic [31:0]     i_dst_addr_mask,
    input  logic [7:0]      i_protocol,
    input  logic [15:0]     i_src_port,
    input  logic [15:0]     i_dst_port,
    input  logic            i_ports_present,
    input  logic            i_rule_action,
    input  logic [31:0]     i_rule_id,
    output fmpf_pkg::t_stat o_stat,
    output logic            o_verdict,
    output logic [1:0]      o_status,
    output logic [31:0]     o_assigned_id
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int RW = fmpf_pkg::RULE_W;

    logic [1:0]  r_op;
    logic [31:0] r_src, r_dst, r_smask, r_dmask, r_id;
    logic [7:0]  r_proto;
    logic [15:0] r_sport, r_dport;
    logic        r_ports_present;
    logic        r_act;
    logic [AW-1:0] r_raddr, r_eaddr;
    logic        r_elast, r_rlast;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [31:0] r_next_id;
    logic        r_verdict, r_hit;
    logic [1:0]  w_status;
    logic [31:0] r_assigned;

    logic [RW-1:0] w_rule, w_rd;
    logic [31:0]   w_rd_id;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic          w_match, w_hit, w_slot_v;
    logic [15:0]   w_psport, w_pdport;
    logic [31:0]   rs, rsm, rd, rdm;
    logic [7:0]    rp;
    logic [15:0]   rsp, rdp;
    logic          ract;

    assign w_rule = {r_src, r_smask, r_dst, r_dmask, r_proto, r_sport, r_dport, r_act};
    assign {rs, rsm, rd, rdm, rp, rsp, rdp, ract} = w_rd;
    assign w_slot_v = r_valid[r_eaddr];

    // Packet ports only for TCP/UDP with port header
    always_comb begin
        w_psport = 16'd0;
        w_pdport = 16'd0;
        if (((r_proto == fmpf_pkg::PROTO_TCP) || (r_proto == fmpf_pkg::PROTO_UDP))
                && r_ports_present) begin
            w_psport = r_sport;
            w_pdport = r_dport;
        end
    end

    // Evaluate the slot read last cycle
    assign w_match = ((rp == 8'd0) || (rp == r_proto))
        && ((rsm == 32'd0) || ((r_src & rsm) == (rs & rsm)))
        && ((rdm == 32'd0) || ((r_dst & rdm) == (rd & rdm)))
        && ((rsp == 16'd0) || (rsp == w_psport))
        && ((rdp == 16'd0) || (rdp == w_pdport));

    always_comb begin
        case (r_op)
            fmpf_pkg::OP_CHECK:  w_hit = w_slot_v && w_match;
            fmpf_pkg::OP_ADD:    w_hit = !w_slot_v;
            fmpf_pkg::OP_DELETE: w_hit = w_slot_v && (w_rd_id == r_id);
            default:             w_hit = 1'b0;
        endcase
    end

    assign w_we = i_cmd.eval && w_hit && (r_op == fmpf_pkg::OP_ADD);
    assign w_waddr = r_eaddr;

    assign o_stat.hit = i_cmd.eval && w_hit;
    assign o_stat.last = r_elast;

    fmpf_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_rule_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_rule),
        .i_raddr(r_raddr), .o_rdata(w_rd)
    );
    fmpf_ram #(.WIDTH(fmpf_pkg::ID_W), .DEPTH(TABLE_DEPTH)) u_id_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_next_id),
        .i_raddr(r_raddr), .o_rdata(w_rd_id)
    );

    // Capture request fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation;
            r_src <= i_src_addr;
            r_dst <= i_dst_addr;
            r_smask <= i_src_addr_mask;
            r_dmask <= i_dst_addr_mask;
            r_proto <= i_protocol;
            r_sport <= i_src_port;
            r_dport <= i_dst_port;
            r_ports_present <= i_ports_present;
            r_act <= i_rule_action;
            r_id <= i_rule_id;
        end
    end

    // Walk slot addresses; read address leads evaluate address by one
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rst) begin
            r_raddr <= '0;
            r_rlast <= (TABLE_DEPTH == 1);
        end else if (i_cmd.scan_adv) begin
            r_eaddr <= r_raddr;
            r_elast <= r_rlast;
            r_raddr <= r_raddr + AW'(1);
            r_rlast <= (r_raddr == AW'(TABLE_DEPTH - 2));
        end
    end

    // Hold valid bits and id counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_next_id <= 32'd1;
        end else begin
            if (i_cmd.clr_valid) begin
                r_valid <= '0;
            end else if (i_cmd.eval && w_hit && (r_op == fmpf_pkg::OP_ADD)) begin
                r_valid[r_eaddr] <= 1'b1;
                r_next_id <= r_next_id + 32'd1;
            end else if (i_cmd.eval && w_hit && (r_op == fmpf_pkg::OP_DELETE)) begin
                r_valid[r_eaddr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit <= 1'b0;
            r_verdict <= 1'b0;
            r_assigned <= 32'd0;
        end else if (i_cmd.eval && w_hit) begin
            r_hit <= 1'b1;
            r_verdict <= (r_op == fmpf_pkg::OP_CHECK) ? ract : 1'b0;
            r_assigned <= (r_op == fmpf_pkg::OP_ADD) ? r_next_id : 32'd0;
        end
    end

    // Form status from op and hit
    always_comb begin
        case (r_op)
            fmpf_pkg::OP_ADD:    w_status = r_hit ? fmpf_pkg::ST_OK : fmpf_pkg::ST_FULL;
            fmpf_pkg::OP_DELETE: w_status = r_hit ? fmpf_pkg::ST_OK : fmpf_pkg::ST_NOT_FOUND;
            default:             w_status = fmpf_pkg::ST_OK;
        endcase
    end

    assign o_verdict = r_verdict;
    assign o_status = w_status;
    assign o_assigned_id = r_assigned;
endmodule

// ===== design/fmpf_checker.sv =====
// Port-level checker for the packet filter table, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fmpf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic        o_verdict,
    input logic [1:0]  o_status,
    input logic [31:0] o_assigned_id
);
    logic w_plain;

    // A check result carries status OK and no id
    assign w_plain = (o_status == fmpf_pkg::ST_OK) && (o_assigned_id == 32'd0);

    `CHK_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "request not taken")
    `CHK_IMPLY(a_done_busy, i_clk, i_rst_n, o_done, busy, "result outside request")
    `CHK_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !busy, "busy after result")
    `CHK_IMPLY(a_excl, i_clk, i_rst_n, o_done && o_verdict, w_plain, "verdict mixed")
    `CHK_IMPLY(a_status, i_clk, i_rst_n, o_done, o_status <= fmpf_pkg::ST_NOT_FOUND, "bad status")
endmodule

bind first_match_packet_filter_table fmpf_checker u_fmpf_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_done(o_done),
    .o_verdict(o_verdict), .o_status(o_status), .o_assigned_id(o_assigned_id)
);
